// File: hw/rtl/xgpr_pkg.sv
// ----------------------------------------------------------------------------
// xgpr_pkg
// Types and constants for the general-register file with flags word.
// ----------------------------------------------------------------------------
package xgpr_pkg;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_WRITE    = 3'd1,
    OP_LAHF     = 3'd2,
    OP_SAHF     = 3'd3,
    OP_LOOP     = 3'd4,
    OP_FLAGS_RD = 3'd5,
    OP_FLAGS_WR = 3'd6,
    OP_NONE     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    WC_BYTE    = 2'd0,
    WC_WORD    = 2'd1,
    WC_DWORD   = 2'd2,
    WC_INVALID = 2'd3
  } width_e;

  localparam logic [1:0] ZC_NONE    = 2'd0;
  localparam logic [1:0] ZC_ZF_SET  = 2'd1;

  localparam logic [7:0] LAHF_MASK  = 8'hD5;
  localparam logic [7:0] FLAG_RSVD  = 8'h02;
  localparam int unsigned ZF_BIT    = 6;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef struct packed {
    logic [1:0]  loop_cond;
    logic        address_size_16;
    logic [31:0] write_value;
    logic [1:0]  width_code;
    logic [3:0]  reg_index;
    logic [2:0]  opcode;
  } item_t;

  typedef struct packed {
    logic        width_error;
    logic        branch_taken;
    logic [31:0] read_data;
  } result_t;

endpackage

// File: hw/rtl/xgpr_exec.sv
// ----------------------------------------------------------------------------
// xgpr_exec
// Single-pass execute logic: next register and flags state and the result
// for one item.
// ----------------------------------------------------------------------------
module xgpr_exec import xgpr_pkg::*; #(
  parameter int unsigned REG_COUNT = 8
) (
  input  item_t       item_i,
  input  logic [31:0] regs_i [REG_COUNT],
  input  logic [31:0] flags_i,
  output logic [31:0] regs_o [REG_COUNT],
  output logic [31:0] flags_o,
  output result_t     result_o
);

  localparam int unsigned IdxW = $clog2(REG_COUNT);
  localparam logic [IdxW-1:0] EaxIdx = IdxW'(0);
  localparam logic [IdxW-1:0] EcxIdx = IdxW'(1);

  logic            in_range;
  logic [IdxW-1:0] full_idx;
  logic [IdxW-1:0] byte_idx;
  logic [31:0]     ecx_dec;
  logic            cnt_nz;
  logic            zf;
  logic            cond;

  assign in_range = {1'b0, item_i.reg_index} < 5'(REG_COUNT);
  assign full_idx = item_i.reg_index[IdxW-1:0];
  assign byte_idx = {{(IdxW-2){1'b0}}, item_i.reg_index[1:0]};
  assign ecx_dec  = regs_i[EcxIdx] - 32'd1;
  assign cnt_nz   = item_i.address_size_16 ? (|ecx_dec[15:0]) : (|ecx_dec);
  assign zf       = flags_i[ZF_BIT];

  always_comb begin
    case (item_i.loop_cond)
      ZC_NONE:   cond = 1'b1;
      ZC_ZF_SET: cond = zf;
      default:   cond = !zf;
    endcase
  end

  always_comb begin
    regs_o   = regs_i;
    flags_o  = flags_i;
    result_o = '0;
    case (op_e'(item_i.opcode))
      OP_READ, OP_WRITE: begin
        case (width_e'(item_i.width_code))
          WC_BYTE: begin
            if (!item_i.reg_index[3]) begin
              if (item_i.opcode == OP_WRITE) begin
                if (item_i.reg_index[2]) begin
                  regs_o[byte_idx][15:8] = item_i.write_value[7:0];
                end else begin
                  regs_o[byte_idx][7:0] = item_i.write_value[7:0];
                end
              end else if (item_i.reg_index[2]) begin
                result_o.read_data = {24'd0, regs_i[byte_idx][15:8]};
              end else begin
                result_o.read_data = {24'd0, regs_i[byte_idx][7:0]};
              end
            end
          end
          WC_WORD: begin
            if (in_range) begin
              if (item_i.opcode == OP_WRITE) begin
                regs_o[full_idx][15:0] = item_i.write_value[15:0];
              end else begin
                result_o.read_data = {16'd0, regs_i[full_idx][15:0]};
              end
            end
          end
          WC_DWORD: begin
            if (in_range) begin
              if (item_i.opcode == OP_WRITE) begin
                regs_o[full_idx] = item_i.write_value;
              end else begin
                result_o.read_data = regs_i[full_idx];
              end
            end
          end
          default: begin
            result_o.width_error = in_range;
          end
        endcase
      end
      OP_LAHF: begin
        regs_o[EaxIdx][15:8] = (flags_i[7:0] & LAHF_MASK) | FLAG_RSVD;
      end
      OP_SAHF: begin
        flags_o[7:0] = (regs_i[EaxIdx][15:8] & LAHF_MASK) | FLAG_RSVD;
      end
      OP_LOOP: begin
        if (item_i.address_size_16) begin
          regs_o[EcxIdx][15:0] = ecx_dec[15:0];
        end else begin
          regs_o[EcxIdx] = ecx_dec;
        end
        result_o.branch_taken = cnt_nz && cond;
      end
      OP_FLAGS_RD: begin
        result_o.read_data = flags_i;
      end
      OP_FLAGS_WR: begin
        flags_o = item_i.write_value;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/x86_gpr_file_partial_access_core.sv
// ----------------------------------------------------------------------------
// x86_gpr_file_partial_access_core
// General-register file with flags word, byte/word/dword access, LAHF, SAHF
// and LOOP.
// An accepted item is held in the input register, executed, and its result
// is held in the result register until taken. Throughput: 1 item per cycle
// unless the output stalls; the register and flags update is one
// read-modify-write in the execute stage between input and result registers.
// Reset: all registers and the flags word clear to zero, both stages empty.
// ----------------------------------------------------------------------------
module x86_gpr_file_partial_access_core import xgpr_pkg::*; #(
  parameter int unsigned REG_COUNT = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // opcode[2:0], reg_index[6:3], width_code[8:7], write_value[40:9],
  // address_size_16[41], loop_cond[43:42], zero[47:44]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // read_data[31:0], branch_taken[32], width_error[33], zero[39:34]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic        in_valid_q;
  item_t       in_item_q;
  logic        out_valid_q;
  result_t     out_res_q;
  logic [31:0] regs_q [REG_COUNT];
  logic [31:0] regs_d [REG_COUNT];
  logic [31:0] flags_q;
  logic [31:0] flags_d;
  result_t     res_d;
  logic        advance;
  logic        fire;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q};

  xgpr_exec #(
    .REG_COUNT(REG_COUNT)
  ) u_exec (
    .item_i  (in_item_q),
    .regs_i  (regs_q),
    .flags_i (flags_q),
    .regs_o  (regs_d),
    .flags_o (flags_d),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        regs_q  <= regs_d;
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= item_t'(s_axis_tdata[43:0]);
    end
    if (fire) begin
      out_res_q <= res_d;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stage empty but not ready");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("executed item produced no result");

  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_item_q.opcode != OP_SAHF && in_item_q.opcode != OP_FLAGS_WR)
      |=> $stable(flags_q))
    else $error("flags changed by an item that does not write them");

  a_branch_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.branch_taken)
      |-> (!out_res_q.width_error && out_res_q.read_data == 32'd0))
    else $error("branch result carries read data or error");

  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.width_error) |-> (out_res_q.read_data == 32'd0))
    else $error("width error result carries read data");

endmodule

// File: tb/sv/x86_gpr_file_partial_access_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_gpr_file_partial_access_check
// Watches both stream channels of the register file. Each accepted item is
// run through a local copy of the registers and flags word to work out its
// result. Each accepted result is compared field by field with the oldest
// result still owed.
// ----------------------------------------------------------------------------
module x86_gpr_file_partial_access_check import xgpr_pkg::*; #(
  parameter int unsigned REG_COUNT = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     checked_o,
  output int                     taken_o,
  output int                     werr_o
);

  localparam int unsigned ACC_IDX   = 0;
  localparam int unsigned COUNT_IDX = 1;
  localparam int unsigned IDX_W     = $clog2(REG_COUNT);

  logic [31:0] gpr_q [REG_COUNT];
  logic [31:0] flags_q;
  result_t     owed_results_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic result_t run_gpr_op(input item_t it);
    result_t          res;
    logic [31:0]      cx_mask;
    logic [31:0]      count;
    logic [4:0]       sh;
    logic [IDX_W-1:0] r;
    logic             cond;
    res = '0;
    case (op_e'(it.opcode))
      OP_READ, OP_WRITE: begin
        if (width_e'(it.width_code) == WC_BYTE) begin
          if (!it.reg_index[3]) begin
            r  = IDX_W'(it.reg_index[1:0]);
            sh = it.reg_index[2] ? 5'd8 : 5'd0;
            if (r < REG_COUNT) begin
              if (it.opcode == OP_WRITE) begin
                gpr_q[r][sh +: 8] = it.write_value[7:0];
              end else begin
                res.read_data = {24'd0, gpr_q[r][sh +: 8]};
              end
            end
          end
        end else if (it.reg_index < REG_COUNT) begin
          r = it.reg_index[IDX_W-1:0];
          case (width_e'(it.width_code))
            WC_WORD: begin
              if (it.opcode == OP_WRITE) begin
                gpr_q[r][15:0] = it.write_value[15:0];
              end else begin
                res.read_data = {16'd0, gpr_q[r][15:0]};
              end
            end
            WC_DWORD: begin
              if (it.opcode == OP_WRITE) begin
                gpr_q[r] = it.write_value;
              end else begin
                res.read_data = gpr_q[r];
              end
            end
            default: res.width_error = 1'b1;
          endcase
        end
      end
      OP_LAHF: gpr_q[ACC_IDX][15:8] = (flags_q[7:0] & LAHF_MASK) | FLAG_RSVD;
      OP_SAHF: flags_q[7:0] = (gpr_q[ACC_IDX][15:8] & LAHF_MASK) | FLAG_RSVD;
      OP_LOOP: begin
        cx_mask = it.address_size_16 ? 32'h0000_FFFF : 32'hFFFF_FFFF;
        count   = (gpr_q[COUNT_IDX] - 32'd1) & cx_mask;
        gpr_q[COUNT_IDX] = (gpr_q[COUNT_IDX] & ~cx_mask) | count;
        case (it.loop_cond)
          ZC_NONE:   cond = 1'b1;
          ZC_ZF_SET: cond = flags_q[ZF_BIT];
          default:   cond = !flags_q[ZF_BIT];
        endcase
        res.branch_taken = (count != 32'd0) && cond;
      end
      OP_FLAGS_RD: res.read_data = flags_q;
      OP_FLAGS_WR: flags_q = it.write_value;
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got;
    result_t want;
    if (!rst_ni) begin
      foreach (gpr_q[i]) gpr_q[i] = '0;
      flags_q = '0;
      owed_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      taken_o      = 0;
      werr_o       = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[$bits(result_t)-1:0];
        if (owed_results_q.size() == 0) begin
          report_mismatch("result with nothing owed", got.read_data, '0);
        end else begin
          want = owed_results_q.pop_front();
          checked_o++;
          if (want.branch_taken) taken_o++;
          if (want.width_error) werr_o++;
          if (got.read_data != want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.branch_taken != want.branch_taken)
            report_mismatch("branch_taken", 32'(got.branch_taken),
                            32'(want.branch_taken));
          if (got.width_error != want.width_error)
            report_mismatch("width_error", 32'(got.width_error),
                            32'(want.width_error));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        owed_results_q.push_back(run_gpr_op(s_tdata_i[$bits(item_t)-1:0]));
      end
      pending_o = owed_results_q.size();
    end
  end

endmodule

// File: tb/sv/x86_gpr_file_partial_access_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_gpr_file_partial_access_core_test
// Drives the register file with a directed set of accesses covering every
// opcode, width and index corner, then about 500 random items under several
// mixes of input gaps and output stalls, including a long output hold-off.
// Results are checked by the companion checker module.
// ----------------------------------------------------------------------------
module x86_gpr_file_partial_access_core_test;
  import xgpr_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 125;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int checked;
  int taken;
  int werr;
  int sent_count;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_cycles = 0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;

  x86_gpr_file_partial_access_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  x86_gpr_file_partial_access_check i_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .taken_o      (taken),
    .werr_o       (werr)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= 300;
      hold_done     <= 1'b1;
    end else if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic item_t make_item(input op_e op, input logic [3:0] idx = '0,
                                      input width_e wc = WC_DWORD,
                                      input logic [31:0] val = '0,
                                      input logic as16 = 1'b0,
                                      input logic [1:0] zc = ZC_NONE);
    item_t it;
    it.opcode          = op;
    it.reg_index       = idx;
    it.width_code      = wc;
    it.write_value     = val;
    it.address_size_16 = as16;
    it.loop_cond       = zc;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30)      it.opcode = OP_READ;
    else if (pick < 55) it.opcode = OP_WRITE;
    else if (pick < 62) it.opcode = OP_LAHF;
    else if (pick < 69) it.opcode = OP_SAHF;
    else if (pick < 82) it.opcode = OP_LOOP;
    else if (pick < 89) it.opcode = OP_FLAGS_RD;
    else if (pick < 96) it.opcode = OP_FLAGS_WR;
    else                it.opcode = OP_NONE;
    it.reg_index       = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                  : 4'($urandom_range(7));
    it.width_code      = ($urandom_range(9) == 0) ? WC_INVALID : 2'($urandom_range(2));
    it.write_value     = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom();
    it.address_size_16 = 1'($urandom_range(1));
    it.loop_cond       = 2'($urandom_range(3));
    return it;
  endfunction

  // start and end on a falling edge; tvalid stays high after the handshake
  task automatic push_item(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(it);
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    item_t directed [$];
    int    n;
    rst_n          = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    sent_count     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed = '{
      make_item(OP_FLAGS_WR, 0, WC_DWORD, 32'hFFFF_FFFF),
      make_item(OP_FLAGS_RD),
      make_item(OP_WRITE, 0, WC_DWORD, 32'h8000_0001),
      make_item(OP_WRITE, 4, WC_BYTE, 32'h0000_005A),
      make_item(OP_READ, 4, WC_BYTE),
      make_item(OP_WRITE, 2, WC_WORD, 32'hFFFF_1234),
      make_item(OP_READ, 2, WC_DWORD),
      make_item(OP_WRITE, 12, WC_BYTE, 32'hFFFF_FFFF),
      make_item(OP_READ, 9, WC_BYTE),
      make_item(OP_WRITE, 8, WC_DWORD, 32'hDEAD_BEEF),
      make_item(OP_READ, 15, WC_WORD),
      make_item(OP_READ, 3, WC_INVALID),
      make_item(OP_WRITE, 7, WC_INVALID, 32'h1234_5678),
      make_item(OP_READ, 10, WC_INVALID),
      make_item(OP_LAHF),
      make_item(OP_READ, 0, WC_DWORD),
      make_item(OP_WRITE, 4, WC_BYTE, 32'h0000_0000),
      make_item(OP_SAHF),
      make_item(OP_FLAGS_RD),
      make_item(OP_WRITE, 1, WC_DWORD, 32'h0000_0000),
      make_item(OP_LOOP, 0, WC_DWORD, 0, 1'b0, ZC_NONE),
      make_item(OP_LOOP, 0, WC_DWORD, 0, 1'b1, ZC_ZF_SET),
      make_item(OP_LOOP, 0, WC_DWORD, 0, 1'b1, 2'b10),
      make_item(OP_WRITE, 1, WC_DWORD, 32'h0000_0001),
      make_item(OP_LOOP, 0, WC_DWORD, 0, 1'b0, 2'b11),
      make_item(OP_NONE, 4'hF, WC_INVALID, 32'hFFFF_FFFF, 1'b1, 2'b11)
    };
    foreach (directed[i]) push_item(directed[i]);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 59; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 59; end
        default: begin src_idle_pct = 29; sink_stall_pct = 29; end
      endcase
      if (phase == 0) begin
        hold_req = 1'b1;
        repeat (40) push_item(random_item());
      end
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(9) == 0) begin
          push_item(make_item(OP_WRITE, 1, WC_DWORD, $urandom_range(1, 4)));
          repeat ($urandom_range(2, 6)) begin
            push_item(make_item(OP_LOOP, 0, WC_DWORD, 0, 1'($urandom_range(1)),
                                2'($urandom_range(3))));
            n++;
          end
        end else begin
          push_item(random_item());
        end
        n++;
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Sent %0d items over all opcodes, widths, in- and out-of-range indices",
             sent_count);
    $display("Checked %0d results (%0d loop branches taken, %0d width errors) %s",
             checked, taken, werr, "under four idle/stall mixes and a long hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
